[sv/dsa_pkg.sv]
package dsa_pkg;

    localparam int DUR_W   = 63;
    localparam int RATE_W  = 32;
    localparam int FRAC_W  = 40;
    localparam int COUNT_W = 64;

    // duration / 1e12 stays below 2^24
    localparam int WHOLE_W = 24;
    // shifted copy of (whole, part) after 31 doublings: whole * 2^31 plus a carry count
    localparam int TQ_W    = 56;
    // whole * rate + fractional quotient, below 2^57
    localparam int ACC_W   = 57;

    localparam int DIV_CNT_W = 5;
    localparam int MUL_CNT_W = 5;

    localparam logic [FRAC_W-1:0]    PS_PER_SECOND = 40'd1000000000000;
    localparam logic [RATE_W-1:0]    RATE_RESET    = 32'd48000;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(WHOLE_W - 1);
    localparam logic [MUL_CNT_W-1:0] MUL_LAST_STEP = MUL_CNT_W'(RATE_W - 1);

    typedef enum logic {
        CMD_CONVERT = 1'b0,
        CMD_CLEAR   = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

endpackage

[sv/dsa_divider.sv]
// Restoring division of the duration by one second in picoseconds, one quotient bit per cycle.
module dsa_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [dsa_pkg::DUR_W-1:0]    dividend,
    output logic                         busy,
    output logic [dsa_pkg::WHOLE_W-1:0]  whole,
    output logic [dsa_pkg::FRAC_W-1:0]   part
);
    import dsa_pkg::*;

    logic [FRAC_W-1:0]    rem_reg, rem_next;
    logic [WHOLE_W-1:0]   low_reg, low_next;
    logic [WHOLE_W-1:0]   quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;

    logic [FRAC_W:0] trial;
    logic [FRAC_W:0] diff;
    logic            ge;

    always_comb begin
        trial = {rem_reg, low_reg[WHOLE_W-1]};
        diff  = trial - {1'b0, PS_PER_SECOND};
        ge    = trial >= {1'b0, PS_PER_SECOND};
    end

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            // top bits alone are below 2^39, hence below the divisor
            rem_next  = {1'b0, dividend[DUR_W-1:WHOLE_W]};
            low_next  = dividend[WHOLE_W-1:0];
            quo_next  = '0;
            cnt_next  = DIV_LAST_STEP;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[FRAC_W-1:0] : trial[FRAC_W-1:0];
            low_next  = {low_reg[WHOLE_W-2:0], 1'b0};
            quo_next  = {quo_reg[WHOLE_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign busy  = busy_reg;
    assign whole = quo_reg;
    assign part  = rem_reg;

endmodule

[sv/dsa_scaler.sv]
// Serial shift-and-add of (whole, part) times rate, reduced modulo one second at every step.
module dsa_scaler (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [dsa_pkg::WHOLE_W-1:0]  whole,
    input  logic [dsa_pkg::FRAC_W-1:0]   part,
    input  logic [dsa_pkg::RATE_W-1:0]   rate,
    output logic                         busy,
    output logic [dsa_pkg::ACC_W-1:0]    quotient,
    output logic [dsa_pkg::FRAC_W-1:0]   remainder
);
    import dsa_pkg::*;

    logic [RATE_W-1:0]    rate_reg, rate_next;
    logic [TQ_W-1:0]      tq_reg, tq_next;
    logic [FRAC_W-1:0]    tr_reg, tr_next;
    logic [ACC_W-1:0]     aq_reg, aq_next;
    logic [FRAC_W-1:0]    ar_reg, ar_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;

    logic [FRAC_W:0] acc_sum, acc_diff;
    logic            acc_wrap;
    logic [FRAC_W:0] dbl, dbl_diff;
    logic            dbl_wrap;

    always_comb begin
        acc_sum  = {1'b0, ar_reg} + {1'b0, tr_reg};
        acc_diff = acc_sum - {1'b0, PS_PER_SECOND};
        acc_wrap = acc_sum >= {1'b0, PS_PER_SECOND};
        dbl      = {tr_reg, 1'b0};
        dbl_diff = dbl - {1'b0, PS_PER_SECOND};
        dbl_wrap = dbl >= {1'b0, PS_PER_SECOND};
    end

    always_comb begin
        rate_next = rate_reg;
        tq_next   = tq_reg;
        tr_next   = tr_reg;
        aq_next   = aq_reg;
        ar_next   = ar_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rate_next = rate;
            tq_next   = TQ_W'(whole);
            tr_next   = part;
            aq_next   = '0;
            ar_next   = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rate_reg[0]) begin
                aq_next = aq_reg + ACC_W'(tq_reg) + ACC_W'(acc_wrap);
                ar_next = acc_wrap ? acc_diff[FRAC_W-1:0] : acc_sum[FRAC_W-1:0];
            end
            // doubling: low bit of the shifted quotient takes the carry out of the fraction
            tq_next   = {tq_reg[TQ_W-2:0], dbl_wrap};
            tr_next   = dbl_wrap ? dbl_diff[FRAC_W-1:0] : dbl[FRAC_W-1:0];
            rate_next = rate_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
            busy_next = (cnt_reg != MUL_LAST_STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rate_reg <= rate_next;
        tq_reg   <= tq_next;
        tr_reg   <= tr_next;
        aq_reg   <= aq_next;
        ar_reg   <= ar_next;
    end

    assign busy      = busy_reg;
    assign quotient  = aq_reg;
    assign remainder = ar_reg;

endmodule

[sv/duration_to_sample_accumulator_core.sv]
// Turns picosecond durations into whole sample counts at the programmed sample rate,
// carrying the leftover fraction of a sample (scaled by 1e12) into the next item and
// keeping a 64-bit running total. A clear item zeroes total and fraction. One item is
// worked at a time: a convert runs the bit-serial divider by 1e12, then the bit-serial
// rate multiplier, then hand-off and the final accumulate; a clear goes straight to the
// result. If the total would pass 64 bits the item returns overflow with a zero count
// and the state is left as it was. The result sits in an output register, so the next
// item is taken while it waits.
module duration_to_sample_accumulator_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [dsa_pkg::RATE_W-1:0]   cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic [dsa_pkg::DUR_W-1:0]    s_duration_ps,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dsa_pkg::COUNT_W-1:0]  m_samples_emitted,
    output logic [dsa_pkg::COUNT_W-1:0]  m_running_total,
    output logic [dsa_pkg::FRAC_W-1:0]   m_carried_fraction,
    output logic                         m_overflow_flag
);
    import dsa_pkg::*;

    state_t state_reg, state_next;

    logic [RATE_W-1:0]  rate_reg;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    command_t           cmd_reg;

    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_samples_reg, out_samples_next;
    logic [COUNT_W-1:0] out_total_reg, out_total_next;
    logic [FRAC_W-1:0]  out_frac_reg, out_frac_next;
    logic               out_ovf_reg, out_ovf_next;

    logic accept, div_start, mul_start, fire;
    logic div_busy, mul_busy;
    logic [WHOLE_W-1:0] div_whole;
    logic [FRAC_W-1:0]  div_part;
    logic [ACC_W-1:0]   mul_quo;
    logic [FRAC_W-1:0]  mul_rem;

    logic [FRAC_W:0]    rem_sum, rem_diff;
    logic               rem_wrap;
    logic [FRAC_W-1:0]  rem_new;
    logic [COUNT_W-1:0] emitted;
    logic [COUNT_W:0]   total_sum;
    logic               ovf;

    dsa_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_duration_ps),
        .busy     (div_busy),
        .whole    (div_whole),
        .part     (div_part)
    );

    dsa_scaler u_scl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mul_start),
        .whole     (div_whole),
        .part      (div_part),
        .rate      (rate_reg),
        .busy      (mul_busy),
        .quotient  (mul_quo),
        .remainder (mul_rem)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (command_t'(s_command) == CMD_CLEAR) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (!mul_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = 1'b0;
        mul_start = 1'b0;
        fire      = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready   = 1'b1;
            ST_DIV:  mul_start = !div_busy;
            ST_MUL:  ;
            ST_DONE: fire      = !out_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign accept    = s_valid && s_ready;
    assign div_start = accept && (command_t'(s_command) == CMD_CONVERT);

    // final accumulate: fraction carry, then total with 64-bit overflow check
    always_comb begin
        rem_sum   = {1'b0, mul_rem} + {1'b0, frac_reg};
        rem_diff  = rem_sum - {1'b0, PS_PER_SECOND};
        rem_wrap  = rem_sum >= {1'b0, PS_PER_SECOND};
        rem_new   = rem_wrap ? rem_diff[FRAC_W-1:0] : rem_sum[FRAC_W-1:0];
        emitted   = COUNT_W'(mul_quo) + COUNT_W'(rem_wrap);
        total_sum = {1'b0, total_reg} + {1'b0, emitted};
        ovf       = total_sum[COUNT_W];
    end

    always_comb begin
        total_next       = total_reg;
        frac_next        = frac_reg;
        out_valid_next   = out_valid_reg;
        out_samples_next = out_samples_reg;
        out_total_next   = out_total_reg;
        out_frac_next    = out_frac_reg;
        out_ovf_next     = out_ovf_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (fire) begin
            out_valid_next = 1'b1;
            if (cmd_reg == CMD_CLEAR) begin
                total_next       = '0;
                frac_next        = '0;
                out_samples_next = '0;
                out_total_next   = '0;
                out_frac_next    = '0;
                out_ovf_next     = 1'b0;
            end else if (ovf) begin
                out_samples_next = '0;
                out_total_next   = total_reg;
                out_frac_next    = frac_reg;
                out_ovf_next     = 1'b1;
            end else begin
                total_next       = total_sum[COUNT_W-1:0];
                frac_next        = rem_new;
                out_samples_next = emitted;
                out_total_next   = total_sum[COUNT_W-1:0];
                out_frac_next    = rem_new;
                out_ovf_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rate_reg      <= RATE_RESET;
            total_reg     <= '0;
            frac_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            frac_reg      <= frac_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                rate_reg <= cfg_wr_data;
            end
        end
        if (accept) begin
            cmd_reg <= command_t'(s_command);
        end
        out_samples_reg <= out_samples_next;
        out_total_reg   <= out_total_next;
        out_frac_reg    <= out_frac_next;
        out_ovf_reg     <= out_ovf_next;
    end

    assign m_valid            = out_valid_reg;
    assign m_samples_emitted  = out_samples_reg;
    assign m_running_total    = out_total_reg;
    assign m_carried_fraction = out_frac_reg;
    assign m_overflow_flag    = out_ovf_reg;

endmodule
